[design/gemm_pkg.sv]
// Shared types, constants and helpers for the matrix multiply-accumulate block.
// Used by gemm_front, gemm_engine and general_matrix_multiply_accumulate.
// Depends on nothing else.
package gemm_pkg;

  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int DIM_W     = 5;
  localparam int DATA_W    = 32;

  // Exact dot product, then the shifted sum split in two halves for the alpha product.
  localparam int ACC_W  = 2 * DATA_W + IDX_W;
  localparam int SH_W   = ACC_W - FRAC_BITS;
  localparam int LO_W   = SH_W / 2;
  localparam int MX_W   = DATA_W + 1;
  localparam int MUL_W  = MX_W + DATA_W;
  localparam int PROD_W = SH_W + DATA_W;
  localparam int SCL_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = SCL_W + 1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OP_W        = 3;
  localparam int PADDR_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A    = 3'd0,
    OP_WR_B    = 3'd1,
    OP_WR_C    = 3'd2,
    OP_COMPUTE = 3'd3,
    OP_RD_C    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_ROWS_A    = 3'd0,
    REG_COLS_B    = 3'd1,
    REG_INNER_LEN = 3'd2,
    REG_ALPHA     = 3'd3,
    REG_BETA      = 3'd4
  } reg_idx_t;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]  rows_a;
    logic [DIM_W-1:0]  cols_b;
    logic [DIM_W-1:0]  inner_len;
    logic [DATA_W-1:0] alpha;
    logic [DATA_W-1:0] beta;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              flag;
  } sat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  // Clamp a wide signed value to 32 bits and report whether it was clipped.
  function automatic sat_t sat32(input logic [SUM_W-1:0] v);
    sat_t r;
    logic [SUM_W-DATA_W:0] top;
    top = v[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      r.value = v[DATA_W-1:0];
      r.flag  = 1'b0;
    end else begin
      r.value = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      r.flag  = 1'b1;
    end
    return r;
  endfunction

endpackage

[design/gemm_front.sv]
// Front end: takes stream words, decodes and classifies the operation, and
// queues legal commands for the engine. Unknown operations are dropped here.
// Depends on gemm_pkg.
module gemm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gemm_pkg::IN_TDATA_W-1:0] s_tdata,  // row[3:0], col[7:4], value[39:8]
  input  logic [gemm_pkg::OP_W-1:0]       s_tuser,  // op[2:0]
  output gemm_pkg::cmd_t                  cmd,
  output logic                           cmd_valid,
  input  logic                           cmd_pop
);
  import gemm_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  cmd_t              queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              legal;
  logic              push;
  logic              pop;
  cmd_t              in_cmd;

  always_comb begin
    in_cmd.op    = op_t'(s_tuser);
    in_cmd.row   = s_tdata[IDX_W-1:0];
    in_cmd.col   = s_tdata[2*IDX_W-1:IDX_W];
    in_cmd.value = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
    case (s_tuser)
      OP_WR_A, OP_WR_B, OP_WR_C, OP_COMPUTE, OP_RD_C: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  assign s_tready  = (count != (QPTR_W+1)'(QDEPTH));
  assign push      = s_tvalid && s_tready && legal;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/gemm_engine.sv]
// Back end: holds the A, B and C stores, runs the compute sequence on one
// shared multiplier and drives the result register. Depends on gemm_pkg.
module gemm_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  gemm_pkg::cfg_t                   cfg,
  input  gemm_pkg::cmd_t                   cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gemm_pkg::OUT_TDATA_W-1:0] m_tdata,  // read_value[31:0], saturated[32]
  output logic                            m_tuser   // kind[0]
);
  import gemm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_BRD  = 10'b00_0000_0010,
    S_BMUL = 10'b00_0000_0100,
    S_BWR  = 10'b00_0000_1000,
    S_DOT  = 10'b00_0001_0000,
    S_ALO  = 10'b00_0010_0000,
    S_AHI  = 10'b00_0100_0000,
    S_ASUM = 10'b00_1000_0000,
    S_AWR  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];
  logic [DATA_W-1:0] c_mem [DEPTH];
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] c_q;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [ADDR_W-1:0] c_raddr;
  logic [ADDR_W-1:0] c_waddr;
  logic [ADDR_W-1:0] cmd_addr;
  logic [DATA_W-1:0] c_wdata;
  logic              a_we;
  logic              b_we;
  logic              c_we;

  logic [DIM_W-1:0]  m_dim;
  logic [DIM_W-1:0]  n_dim;
  logic [DIM_W-1:0]  k_dim;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [DIM_W-1:0]  iss;
  logic              issuing;
  logic              rd_v;
  logic              mul_v;
  logic              last_i;
  logic              last_j;
  logic              beta_zero;
  logic              alpha_zero;

  logic signed [MX_W-1:0]   mul_x;
  logic signed [DATA_W-1:0] mul_y;
  logic signed [MUL_W-1:0]  mul;
  logic        [MUL_W-1:0]  plo;
  logic        [ACC_W-1:0]  acc;
  logic        [SH_W-1:0]   sh;
  logic        [PROD_W-1:0] full;
  logic        [SCL_W-1:0]  scaled;
  sat_t                     beta_sat;
  sat_t                     final_sat;
  logic                     sat_seen;
  logic                     out_kind;
  logic                     out_free;

  assign cmd_addr   = {cmd.row, cmd.col};
  assign beta_zero  = (cfg.beta == '0);
  assign alpha_zero = (cfg.alpha == '0);
  assign issuing    = (iss < k_dim);
  assign last_i     = (DIM_W'(i) == m_dim - DIM_W'(1));
  assign last_j     = (DIM_W'(j) == n_dim - DIM_W'(1));
  assign out_free   = !m_tvalid || m_tready;
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign sh         = acc[ACC_W-1:FRAC_BITS];

  always_comb begin
    a_raddr = {i, iss[IDX_W-1:0]};
    b_raddr = {iss[IDX_W-1:0], j};
    c_raddr = (state == S_IDLE) ? cmd_addr : {i, j};

    case (state)
      S_DOT: begin
        mul_x = MX_W'($signed(a_q));
        mul_y = $signed(b_q);
      end
      S_BMUL: begin
        mul_x = MX_W'($signed(c_q));
        mul_y = $signed(cfg.beta);
      end
      S_ALO: begin
        mul_x = $signed({{(MX_W-LO_W){1'b0}}, sh[LO_W-1:0]});
        mul_y = $signed(cfg.alpha);
      end
      S_AHI: begin
        mul_x = MX_W'($signed(sh[SH_W-1:LO_W]));
        mul_y = $signed(cfg.alpha);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase

    // The alpha product is rebuilt from its two partial products.
    full = (PROD_W'($signed(mul)) << LO_W) + PROD_W'($signed(plo));

    beta_sat  = sat32(SUM_W'($signed(mul[2*DATA_W-1:FRAC_BITS])));
    final_sat = sat32(SUM_W'($signed(scaled)) + SUM_W'($signed(c_q)));

    a_we    = 1'b0;
    b_we    = 1'b0;
    c_we    = 1'b0;
    c_waddr = {i, j};
    c_wdata = cmd.value;
    case (state)
      S_IDLE: begin
        c_waddr = cmd_addr;
        a_we    = cmd_valid && (cmd.op == OP_WR_A);
        b_we    = cmd_valid && (cmd.op == OP_WR_B);
        c_we    = cmd_valid && (cmd.op == OP_WR_C);
      end
      S_BWR: begin
        c_we    = 1'b1;
        c_wdata = beta_zero ? '0 : beta_sat.value;
      end
      S_AWR: begin
        c_we    = 1'b1;
        c_wdata = final_sat.value;
      end
      default: begin
        c_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[cmd_addr] <= cmd.value;
    end
    a_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[cmd_addr] <= cmd.value;
    end
    b_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_q <= c_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    mul <= mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sat_seen <= 1'b0;
      m_tvalid <= 1'b0;
      rd_v     <= 1'b0;
      mul_v    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_COMPUTE: begin
                sat_seen <= 1'b0;
                m_dim    <= clamp_dim(cfg.rows_a);
                n_dim    <= clamp_dim(cfg.cols_b);
                k_dim    <= clamp_dim(cfg.inner_len);
                i        <= '0;
                j        <= '0;
                out_kind <= KIND_DONE;
                if (cfg.rows_a == '0 || cfg.cols_b == '0 || cfg.inner_len == '0) begin
                  state <= S_OUT;
                end else if (beta_zero) begin
                  state <= S_BWR;
                end else begin
                  state <= S_BRD;
                end
              end
              OP_RD_C: begin
                // Holding the address in i and j keeps the read data steady
                // while the result word waits for the receiver.
                i        <= cmd.row;
                j        <= cmd.col;
                out_kind <= KIND_READ;
                state    <= S_OUT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_BRD: begin
          state <= S_BMUL;
        end
        S_BMUL: begin
          state <= S_BWR;
        end
        S_BWR: begin
          if (!beta_zero && beta_sat.flag) begin
            sat_seen <= 1'b1;
          end
          j <= last_j ? '0 : j + 1'b1;
          i <= last_j ? i + 1'b1 : i;
          if (last_i && last_j) begin
            i <= '0;
            j <= '0;
            if (alpha_zero) begin
              state <= S_OUT;
            end else begin
              iss   <= '0;
              acc   <= '0;
              state <= S_DOT;
            end
          end else begin
            state <= beta_zero ? S_BWR : S_BRD;
          end
        end
        S_DOT: begin
          // Reads, products and the running sum overlap, one term per cycle.
          if (issuing) begin
            iss <= iss + 1'b1;
          end
          rd_v  <= issuing;
          mul_v <= rd_v;
          if (mul_v) begin
            acc <= acc + ACC_W'($signed(mul));
          end
          if (!issuing && !rd_v && !mul_v) begin
            state <= S_ALO;
          end
        end
        S_ALO: begin
          state <= S_AHI;
        end
        S_AHI: begin
          plo   <= mul;
          state <= S_ASUM;
        end
        S_ASUM: begin
          scaled <= full[PROD_W-1:FRAC_BITS];
          state  <= S_AWR;
        end
        S_AWR: begin
          if (final_sat.flag) begin
            sat_seen <= 1'b1;
          end
          j   <= last_j ? '0 : j + 1'b1;
          i   <= last_j ? i + 1'b1 : i;
          iss <= '0;
          acc <= '0;
          state <= (last_i && last_j) ? S_OUT : S_DOT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= out_kind;
            m_tdata  <= {{(OUT_TDATA_W-DATA_W-1){1'b0}}, sat_seen,
                         (out_kind == KIND_READ) ? c_q : {DATA_W{1'b0}}};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/general_matrix_multiply_accumulate.sv]
// Top level of the matrix multiply-accumulate block: configuration registers
// on the APB port, front end queue and compute engine. Depends on gemm_pkg.
//
// Computes C = alpha*A*B + beta*C on Q16.16 matrices of up to 16 by 16. Words
// on the input stream load A, B or C one element each, start a compute, or read
// back one element of C, and a four-word queue lets the stream keep running
// while the engine is busy. A compute first scales the C region by beta (if
// beta is zero it skips the read and multiply and writes zeros), then, unless
// alpha is zero, forms each element of C in turn; its run time is set by the
// single read port of each store and the one 33x32 multiplier that every
// product goes through.
// Compute and read each return one word: kind 0 for a finished compute, kind 1
// with the element for a read, both with the saturation flag of the last
// compute. Registers must only be written while the block is idle.
module general_matrix_multiply_accumulate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gemm_pkg::IN_TDATA_W-1:0]  s_tdata,  // row[3:0], col[7:4], value[39:8]
  input  logic [gemm_pkg::OP_W-1:0]        s_tuser,  // op[2:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gemm_pkg::OUT_TDATA_W-1:0] m_tdata,  // read_value[31:0], saturated[32]
  output logic                             m_tuser,  // kind[0]
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gemm_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import gemm_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  logic     cmd_valid;
  logic     cmd_pop;
  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_a    <= '0;
      cfg.cols_b    <= '0;
      cfg.inner_len <= '0;
      cfg.alpha     <= DATA_W'(1) << FRAC_BITS;
      cfg.beta      <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ROWS_A:    cfg.rows_a    <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cfg.cols_b    <= pwdata[DIM_W-1:0];
        REG_INNER_LEN: cfg.inner_len <= pwdata[DIM_W-1:0];
        REG_ALPHA:     cfg.alpha     <= pwdata;
        REG_BETA:      cfg.beta      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROWS_A:    prdata = 32'(cfg.rows_a);
      REG_COLS_B:    prdata = 32'(cfg.cols_b);
      REG_INNER_LEN: prdata = 32'(cfg.inner_len);
      REG_ALPHA:     prdata = cfg.alpha;
      REG_BETA:      prdata = cfg.beta;
      default:       prdata = '0;
    endcase
  end

  gemm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  gemm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[tb/sv/gemm_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the matrix multiply-accumulate block. It watches the APB port and
// both streams, predicts every result word and compares it field by field.
// Depends on gemm_pkg only.
module gemm_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [gemm_pkg::IN_TDATA_W-1:0]  s_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [gemm_pkg::OP_W-1:0]        s_tuser,   // op[2:0]
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [gemm_pkg::OUT_TDATA_W-1:0] m_tdata,   // read_value[31:0], saturated[32]
  input  logic                             m_tuser,   // kind[0]
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gemm_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  input  logic                             pready,
  output int                               errors,
  output int                               pending,
  output int                               results_checked
);
  import gemm_pkg::*;

  localparam logic signed [127:0] WORD_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] WORD_MIN = -128'sh8000_0000;

  typedef struct {
    logic              kind;
    logic [DATA_W-1:0] value;
    logic              sat;
  } reply_t;

  logic signed [DATA_W-1:0] a_mat [DEPTH];
  logic signed [DATA_W-1:0] b_mat [DEPTH];
  logic signed [DATA_W-1:0] c_mat [DEPTH];
  logic                     sat_seen;
  logic [DIM_W-1:0]         rows_a;
  logic [DIM_W-1:0]         cols_b;
  logic [DIM_W-1:0]         inner_len;
  logic signed [DATA_W-1:0] alpha;
  logic signed [DATA_W-1:0] beta;

  reply_t replies_due [$];
  reply_t due;
  int     at;
  int     fail_count = 0;
  int     seen = 0;

  function automatic int usable_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // Any value outside the signed 32-bit range is clipped and marks the compute.
  function automatic logic [DATA_W-1:0] clip_word(input logic signed [127:0] v);
    if (v > WORD_MAX) begin
      sat_seen = 1'b1;
      return WORD_MAX[DATA_W-1:0];
    end
    if (v < WORD_MIN) begin
      sat_seen = 1'b1;
      return WORD_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  task automatic update_c_matrix();
    int m, n, kk, i, j, p, idx;
    logic signed [127:0] acc, av, bv, al, be, cv;
    m  = usable_dim(rows_a);
    n  = usable_dim(cols_b);
    kk = usable_dim(inner_len);
    al = alpha;
    be = beta;
    sat_seen = 1'b0;
    if (m == 0 || n == 0 || kk == 0) return;
    // The beta pass covers the whole region before any product is added.
    for (i = 0; i < m; i++) begin
      for (j = 0; j < n; j++) begin
        idx = i * MAX_DIM + j;
        if (be == 0) begin
          c_mat[idx] = '0;
        end else begin
          cv = c_mat[idx];
          c_mat[idx] = clip_word((cv * be) >>> FRAC_BITS);
        end
      end
    end
    if (al == 0) return;
    for (i = 0; i < m; i++) begin
      for (j = 0; j < n; j++) begin
        idx = i * MAX_DIM + j;
        acc = '0;
        for (p = 0; p < kk; p++) begin
          av = a_mat[i * MAX_DIM + p];
          bv = b_mat[p * MAX_DIM + j];
          acc = acc + av * bv;
        end
        acc = acc >>> FRAC_BITS;
        acc = (acc * al) >>> FRAC_BITS;
        cv = c_mat[idx];
        c_mat[idx] = clip_word(acc + cv);
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_a    = '0;
      cols_b    = '0;
      inner_len = '0;
      alpha     = DATA_W'(1) << FRAC_BITS;
      beta      = '0;
      sat_seen  = 1'b0;
      replies_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_ROWS_A:    rows_a    = pwdata[DIM_W-1:0];
          REG_COLS_B:    cols_b    = pwdata[DIM_W-1:0];
          REG_INNER_LEN: inner_len = pwdata[DIM_W-1:0];
          REG_ALPHA:     alpha     = pwdata[DATA_W-1:0];
          REG_BETA:      beta      = pwdata[DATA_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        at = int'(s_tdata[IDX_W-1:0]) * MAX_DIM + int'(s_tdata[2*IDX_W-1:IDX_W]);
        case (s_tuser)
          OP_WR_A: a_mat[at] = s_tdata[2*IDX_W +: DATA_W];
          OP_WR_B: b_mat[at] = s_tdata[2*IDX_W +: DATA_W];
          OP_WR_C: c_mat[at] = s_tdata[2*IDX_W +: DATA_W];
          OP_COMPUTE: begin
            update_c_matrix();
            replies_due.push_back('{kind: KIND_DONE, value: '0, sat: sat_seen});
          end
          OP_RD_C: replies_due.push_back('{kind: KIND_READ, value: c_mat[at], sat: sat_seen});
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen++;
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: expected no result word, got kind %0d value %h sat %0d",
                   $time, m_tuser, m_tdata[DATA_W-1:0], m_tdata[DATA_W]);
        end else begin
          due = replies_due.pop_front();
          if (m_tuser !== due.kind) begin
            flag_mismatch("kind", DATA_W'(due.kind), DATA_W'(m_tuser));
          end
          if (m_tdata[DATA_W-1:0] !== due.value) begin
            flag_mismatch("read_value", due.value, m_tdata[DATA_W-1:0]);
          end
          if (m_tdata[DATA_W] !== due.sat) begin
            flag_mismatch("saturated", DATA_W'(due.sat), DATA_W'(m_tdata[DATA_W]));
          end
        end
      end
    end
    errors          <= fail_count;
    pending         <= replies_due.size();
    results_checked <= seen;
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the matrix multiply-accumulate block: clock, reset, stream and
// APB stimulus, and the verdict. Depends on gemm_pkg, gemm_checker and the block.
module tb_top;
  import gemm_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int PHASE_WORDS  = 64;
  localparam int MAX_WAIT     = 17;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 3_000_000;

  localparam logic [OP_W-1:0]   OP_FIRST_UNUSED = OP_W'(OP_RD_C) + 1'b1;
  localparam logic [DATA_W-1:0] Q_ONE       = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] FULL_POS    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] FULL_NEG    = 32'h8000_0000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // row[3:0], col[7:4], value[39:8]
  logic [OP_W-1:0]        s_tuser;   // op[2:0]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // read_value[31:0], saturated[32]
  logic                   m_tuser;   // kind[0]
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int chk_errors;
  int chk_pending;
  int chk_checked;

  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int cycle_count = 0;
  int words_sent  = 0;
  int useful_sent = 0;
  int computes    = 0;
  int settings    = 0;

  general_matrix_multiply_accumulate i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  gemm_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .errors          (chk_errors),
    .pending         (chk_pending),
    .results_checked (chk_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still due", cycle_count, chk_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Unless the sink is set steady, the receiver stalls for a fresh random number of cycles after every word it takes.
  initial begin : result_sink
    int hold;
    m_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_tready && m_tvalid) hold = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      4, 5:       return $urandom_range(0, 16) - 8;
      6:          return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
      7: begin
        case ($urandom_range(0, 5))
          0:       return FULL_POS;
          1:       return FULL_NEG;
          2:       return '0;
          3:       return Q_ONE;
          4:       return Q_MINUS_ONE;
          default: return '1;
        endcase
      end
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] draw_scale();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return Q_ONE;
      3:       return Q_MINUS_ONE;
      4, 5:    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      6:       return $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
      7:       return $urandom_range(0, 32'hFFFF);
      default: return draw_value();
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] draw_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return DIM_W'($urandom_range(1, 5));
    if (r == 6) return '0;
    if (r < 9) return DIM_W'($urandom_range(6, MAX_DIM));
    return DIM_W'($urandom_range(MAX_DIM + 1, 2**DIM_W - 1));
  endfunction

  // Mostly an index inside the active region, so computes pick up fresh data.
  function automatic logic [IDX_W-1:0] pick_index(input int limit);
    if (limit == 0 || $urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, MAX_DIM - 1));
    return IDX_W'($urandom_range(0, limit - 1));
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {value, col, row};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (op <= OP_RD_C) useful_sent++;
    if (op == OP_COMPUTE) computes++;
  endtask

  // Stop the stream, let every expected result arrive, then give the engine time
  // to finish any trailing loads that produce no result.
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
                            input logic [DIM_W-1:0] kk, input logic [DATA_W-1:0] al,
                            input logic [DATA_W-1:0] be);
    quiesce();
    apb_write(REG_ROWS_A, 32'(m));
    apb_write(REG_COLS_B, 32'(n));
    apb_write(REG_INNER_LEN, 32'(kk));
    apb_write(REG_ALPHA, al);
    apb_write(REG_BETA, be);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] m, n, kk;
    int rm, rn, rk, pick, i, phase, stop_at;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load every entry of all three stores so that no later compute or read
    // touches an entry that was never written.
    for (i = 0; i < DEPTH; i++) begin
      send_word(OP_WR_A, IDX_W'(i / MAX_DIM), IDX_W'(i % MAX_DIM), draw_value());
      send_word(OP_WR_B, IDX_W'(i / MAX_DIM), IDX_W'(i % MAX_DIM), draw_value());
      send_word(OP_WR_C, IDX_W'(i / MAX_DIM), IDX_W'(i % MAX_DIM), draw_value());
    end

    // Reset dimensions are zero: compute leaves C alone and clears the flag.
    send_word(OP_COMPUTE, '0, '0, draw_value());
    send_word(OP_RD_C, '0, '0, '0);
    send_word(OP_RD_C, '1, '1, '1);

    // Full-scale dot product saturates high.
    set_config(5'd2, 5'd2, 5'd2, Q_ONE, '0);
    send_word(OP_WR_A, 4'd0, 4'd0, FULL_POS);
    send_word(OP_WR_A, 4'd0, 4'd1, FULL_POS);
    send_word(OP_WR_B, 4'd0, 4'd0, FULL_POS);
    send_word(OP_WR_B, 4'd1, 4'd0, FULL_POS);
    send_word(OP_COMPUTE, '0, '0, '0);
    send_word(OP_RD_C, 4'd0, 4'd0, '0);
    send_word(OP_RD_C, 4'd1, 4'd1, '0);

    // Unused ops are dropped without a reply.
    for (i = OP_FIRST_UNUSED; i < 2**OP_W; i++) begin
      send_word(OP_W'(i), '1, '0, $urandom());
    end

    // Zero alpha only scales C, and the largest beta pushes it below range.
    set_config(5'd1, 5'd1, 5'd1, '0, FULL_POS);
    send_word(OP_WR_C, 4'd0, 4'd0, FULL_NEG);
    send_word(OP_COMPUTE, '0, '0, '0);
    send_word(OP_RD_C, 4'd0, 4'd0, '0);

    // Oversized dimensions act as the full size; minus one as beta overflows
    // the most negative value.
    set_config(5'd31, 5'd17, 5'd16, FULL_NEG, Q_MINUS_ONE);
    send_word(OP_COMPUTE, '0, '0, '0);
    send_word(OP_RD_C, 4'd15, 4'd15, '0);
    send_word(OP_RD_C, 4'd0, 4'd0, '0);

    stop_at = useful_sent + RANDOM_WORDS;
    phase = 0;
    while (useful_sent < stop_at) begin
      phase++;
      m  = draw_dim();
      n  = draw_dim();
      kk = draw_dim();
      rm = (m > MAX_DIM) ? MAX_DIM : m;
      rn = (n > MAX_DIM) ? MAX_DIM : n;
      rk = (kk > MAX_DIM) ? MAX_DIM : kk;
      set_config(m, n, kk, draw_scale(), draw_scale());
      src_steady  = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      for (i = 0; i < PHASE_WORDS && useful_sent < stop_at; i++) begin
        // Now and then the sender holds off until nothing is outstanding.
        if (phase % 3 == 1 && i == PHASE_WORDS / 2) quiesce();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          send_word(OP_WR_A, pick_index(rm), pick_index(rk), draw_value());
        end else if (pick < 40) begin
          send_word(OP_WR_B, pick_index(rk), pick_index(rn), draw_value());
        end else if (pick < 52) begin
          send_word(OP_WR_C, pick_index(rm), pick_index(rn), draw_value());
        end else if (pick < 60) begin
          send_word(OP_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()), draw_value());
        end else if (pick < 93) begin
          send_word(OP_RD_C, pick_index(rm), pick_index(rn), draw_value());
        end else begin
          send_word(OP_W'($urandom_range(OP_FIRST_UNUSED, 2**OP_W - 1)),
                    IDX_W'($urandom()), IDX_W'($urandom()), draw_value());
        end
      end
    end

    src_steady  = 1'b0;
    sink_steady = 1'b0;
    quiesce();
    $display("Sent %0d words (%0d computes) across %0d register settings and %0d random phases.",
             words_sent, computes, settings, phase);
    $display("Checked %0d result words, including saturation and oversized dimensions.",
             chk_checked);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
